// ===== src/i2cmrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the I2C register transfer master.
// No dependencies; imported by the top level.
package i2cmrt_pkg;

    localparam int unsigned CFG_W = 8;
    localparam logic [CFG_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_START_WR = 2'd1,
        FUNC_START_RD = 2'd2,
        FUNC_SUPPLY   = 2'd3
    } t_func;

    localparam logic [7:0] ADDR_RD_BIT = 8'h01;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== src/i2c_master_register_transfer.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; input ready drops only while the
// output register holds a word that is not taken in the same cycle.
// Reset (i_rst_n low, synchronous): bus idle, internal SCL and SDA state high,
// ack poll limit back to 250, no result pending.
// Top level of the I2C register transfer master; uses i2cmrt_pkg.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_wr_byte,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_released,
    output logic [7:0] o_rd_byte,
    output logic       o_rd_valid,
    output logic       o_byte_wanted,
    output logic       o_done_res,
    output logic       o_nack_error,
    output logic       o_busy_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_TXL, PH_TXH, PH_AKL, PH_AKH, PH_WANT,
        PH_RS0, PH_RS1, PH_RS2, PH_RBL, PH_RBH, PH_MAL, PH_MAH,
        PH_P0, PH_P1, PH_P2
    } t_phase;

    typedef enum logic [1:0] {
        STG_ADDR_W, STG_REG, STG_DATA, STG_ADDR_R
    } t_stage;

    logic [7:0] r_ack_poll_limit;

    t_phase     r_phase, n_phase;
    t_stage     r_stage, n_stage;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift_reg, n_shift_reg;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_poll_count, n_poll_count;
    logic [6:0] r_target_addr, n_target_addr;
    logic [7:0] r_register_addr, n_register_addr;
    logic       r_is_read, n_is_read;
    logic [7:0] r_pending_byte, n_pending_byte;
    logic       r_pending_valid, n_pending_valid;
    logic       r_err_flag, n_err_flag;
    logic       r_line_scl, n_line_scl;
    logic       r_line_sda, n_line_sda;
    logic       r_line_rel, n_line_rel;

    logic       n_rd_valid, n_done, n_nerr;
    logic [7:0] n_rd_byte;

    logic       r_out_valid;
    logic       r_o_scl, r_o_sda, r_o_rel, r_o_rd_valid, r_o_wanted;
    logic       r_o_done, r_o_nerr, r_o_busy;
    logic [7:0] r_o_rd_byte;

    logic       accept;
    logic       last_byte;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign last_byte  = (r_bytes_left <= 8'd1);

    always_comb begin
        n_phase         = r_phase;
        n_stage         = r_stage;
        n_bit_count     = r_bit_count;
        n_shift_reg     = r_shift_reg;
        n_bytes_left    = r_bytes_left;
        n_poll_count    = r_poll_count;
        n_target_addr   = r_target_addr;
        n_register_addr = r_register_addr;
        n_is_read       = r_is_read;
        n_pending_byte  = r_pending_byte;
        n_pending_valid = r_pending_valid;
        n_err_flag      = r_err_flag;
        n_line_scl      = r_line_scl;
        n_line_sda      = r_line_sda;
        n_line_rel      = r_line_rel;
        n_rd_valid      = 1'b0;
        n_rd_byte       = 8'd0;
        n_done          = 1'b0;
        n_nerr          = 1'b0;

        unique case (t_func'(i_func))
            FUNC_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_ST0: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b110;
                        n_phase = PH_ST1;
                    end
                    PH_ST1: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b100;
                        n_shift_reg = {r_target_addr, 1'b0};
                        n_bit_count = '0;
                        n_stage     = STG_ADDR_W;
                        n_phase     = PH_TXL;
                    end
                    PH_TXL: begin
                        {n_line_scl, n_line_sda, n_line_rel} = {1'b0, r_shift_reg[7], 1'b0};
                        n_phase = PH_TXH;
                    end
                    PH_TXH: begin
                        {n_line_scl, n_line_sda, n_line_rel} = {1'b1, r_shift_reg[7], 1'b0};
                        n_shift_reg = {r_shift_reg[6:0], 1'b0};
                        n_bit_count = r_bit_count + 4'd1;
                        n_phase     = (n_bit_count >= BITS_PER_BYTE) ? PH_AKL : PH_TXL;
                    end
                    PH_AKL: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b011;
                        n_poll_count = '0;
                        n_phase      = PH_AKH;
                    end
                    PH_AKH: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b111;
                        if (!i_sda_in) begin
                            unique case (r_stage)
                                STG_ADDR_W: begin
                                    n_shift_reg = r_register_addr;
                                    n_bit_count = '0;
                                    n_stage     = STG_REG;
                                    n_phase     = PH_TXL;
                                end
                                STG_REG: begin
                                    if (r_is_read) begin
                                        n_phase = PH_RS0;
                                    end else begin
                                        n_phase = (r_bytes_left != '0) ? PH_WANT : PH_P0;
                                    end
                                end
                                STG_DATA: begin
                                    n_phase = (r_bytes_left != '0) ? PH_WANT : PH_P0;
                                end
                                STG_ADDR_R: begin
                                    if (r_bytes_left != '0) begin
                                        n_bit_count = '0;
                                        n_shift_reg = '0;
                                        n_phase     = PH_RBL;
                                    end else begin
                                        n_phase = PH_P0;
                                    end
                                end
                            endcase
                        end else if (r_poll_count >= r_ack_poll_limit) begin
                            // ack timeout: abort with STOP
                            n_err_flag = 1'b1;
                            n_phase    = PH_P0;
                        end else begin
                            n_poll_count = r_poll_count + 8'd1;
                        end
                    end
                    PH_WANT: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b000;
                        if (r_pending_valid) begin
                            n_pending_valid = 1'b0;
                            if (r_bytes_left != '0) begin
                                n_bytes_left = r_bytes_left - 8'd1;
                            end
                            n_shift_reg = r_pending_byte;
                            n_bit_count = '0;
                            n_stage     = STG_DATA;
                            n_phase     = PH_TXL;
                        end
                    end
                    PH_RS0: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b010;
                        n_phase = PH_RS1;
                    end
                    PH_RS1: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b110;
                        n_phase = PH_RS2;
                    end
                    PH_RS2: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b100;
                        n_shift_reg = {r_target_addr, 1'b0} | ADDR_RD_BIT;
                        n_bit_count = '0;
                        n_stage     = STG_ADDR_R;
                        n_phase     = PH_TXL;
                    end
                    PH_RBL: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b011;
                        n_phase = PH_RBH;
                    end
                    PH_RBH: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b111;
                        n_shift_reg = {r_shift_reg[6:0], i_sda_in};
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count >= BITS_PER_BYTE) begin
                            n_rd_valid = 1'b1;
                            n_rd_byte  = n_shift_reg;
                            n_phase    = PH_MAL;
                        end else begin
                            n_phase = PH_RBL;
                        end
                    end
                    PH_MAL: begin
                        // master ACK, NACK on the last byte
                        {n_line_scl, n_line_sda, n_line_rel} = {1'b0, last_byte, 1'b0};
                        n_phase = PH_MAH;
                    end
                    PH_MAH: begin
                        {n_line_scl, n_line_sda, n_line_rel} = {1'b1, last_byte, 1'b0};
                        if (r_bytes_left != '0) begin
                            n_bytes_left = r_bytes_left - 8'd1;
                        end
                        if (n_bytes_left != '0) begin
                            n_bit_count = '0;
                            n_shift_reg = '0;
                            n_phase     = PH_RBL;
                        end else begin
                            n_phase = PH_P0;
                        end
                    end
                    PH_P0: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b000;
                        n_phase = PH_P1;
                    end
                    PH_P1: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b100;
                        n_phase = PH_P2;
                    end
                    PH_P2: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b110;
                        n_done          = 1'b1;
                        n_nerr          = r_err_flag;
                        n_err_flag      = 1'b0;
                        n_pending_valid = 1'b0;
                        n_phase         = PH_IDLE;
                    end
                    default: begin
                        {n_line_scl, n_line_sda, n_line_rel} = 3'b110;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            FUNC_START_WR, FUNC_START_RD: begin
                if (r_phase == PH_IDLE) begin
                    n_target_addr   = i_dev_addr;
                    n_register_addr = i_reg_addr;
                    n_bytes_left    = i_byte_count;
                    n_is_read       = (t_func'(i_func) == FUNC_START_RD);
                    n_pending_valid = 1'b0;
                    n_err_flag      = 1'b0;
                    n_poll_count    = '0;
                    n_bit_count     = '0;
                    n_shift_reg     = '0;
                    n_stage         = STG_ADDR_W;
                    n_phase         = PH_ST0;
                end
            end
            FUNC_SUPPLY: begin
                // a newer byte replaces one not yet sent
                if (r_phase != PH_IDLE && !r_is_read) begin
                    n_pending_byte  = i_wr_byte;
                    n_pending_valid = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_poll_limit <= ACK_POLL_LIMIT_RST;
            r_phase          <= PH_IDLE;
            r_stage          <= STG_ADDR_W;
            r_bit_count      <= '0;
            r_shift_reg      <= '0;
            r_bytes_left     <= '0;
            r_poll_count     <= '0;
            r_target_addr    <= '0;
            r_register_addr  <= '0;
            r_is_read        <= 1'b0;
            r_pending_valid  <= 1'b0;
            r_err_flag       <= 1'b0;
            r_line_scl       <= 1'b1;
            r_line_sda       <= 1'b1;
            r_line_rel       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ack_poll_limit <= i_cfg_data;
            end
            if (accept) begin
                r_phase         <= n_phase;
                r_stage         <= n_stage;
                r_bit_count     <= n_bit_count;
                r_shift_reg     <= n_shift_reg;
                r_bytes_left    <= n_bytes_left;
                r_poll_count    <= n_poll_count;
                r_target_addr   <= n_target_addr;
                r_register_addr <= n_register_addr;
                r_is_read       <= n_is_read;
                r_pending_valid <= n_pending_valid;
                r_err_flag      <= n_err_flag;
                r_line_scl      <= n_line_scl;
                r_line_sda      <= n_line_sda;
                r_line_rel      <= n_line_rel;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pending_byte <= n_pending_byte;
            r_o_scl        <= n_line_scl;
            r_o_sda        <= n_line_sda;
            r_o_rel        <= n_line_rel;
            r_o_rd_byte    <= n_rd_byte;
            r_o_rd_valid   <= n_rd_valid;
            r_o_wanted     <= (n_phase == PH_WANT) && !n_pending_valid;
            r_o_done       <= n_done;
            r_o_nerr       <= n_nerr;
            r_o_busy       <= (n_phase != PH_IDLE);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_o_scl;
    assign o_sda_level    = r_o_sda;
    assign o_sda_released = r_o_rel;
    assign o_rd_byte      = r_o_rd_byte;
    assign o_rd_valid     = r_o_rd_valid;
    assign o_byte_wanted  = r_o_wanted;
    assign o_done_res     = r_o_done;
    assign o_nack_error   = r_o_nerr;
    assign o_busy_res     = r_o_busy;

endmodule

// ===== src/i2cmrt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the I2C register transfer master, with its bind.
// Depends on i2c_master_register_transfer port names.
module i2cmrt_sva (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_wr_byte,
    input  logic       i_sda_in,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic       o_scl_level,
    input  logic       o_sda_level,
    input  logic       o_sda_released,
    input  logic [7:0] o_rd_byte,
    input  logic       o_rd_valid,
    input  logic       o_byte_wanted,
    input  logic       o_done_res,
    input  logic       o_nack_error,
    input  logic       o_busy_res
);

    // STOP finishes the transaction
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && o_scl_level && o_sda_level)
        else $error("done word still busy or lines not released");

    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_nack_error |-> o_done_res)
        else $error("nack error without done");

    // received byte completes on SCL high with SDA sampled
    a_rd_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rd_valid |-> o_scl_level && o_sda_released && o_busy_res)
        else $error("read byte outside a sampling phase");

    // the wait can be entered straight from the ack phase, lines still high
    a_want_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_wanted |-> o_busy_res && !o_rd_valid && !o_done_res)
        else $error("byte request outside write wait");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rd_byte)
            && $stable(o_done_res) && $stable(o_busy_res))
        else $error("stalled result word changed");

endmodule

bind i2c_master_register_transfer i2cmrt_sva u_i2cmrt_sva (.*);
